// ===== design/acktt_pkg.sv =====
// shared types and constants of the ack retransmit tracking table
// no dependencies; every other design file refers to this package by scoped names

package acktt_pkg;

  localparam int SlotsDef = 32;

  localparam int OpW   = 2;
  localparam int ByteW = 8;
  localparam int IdW   = 32;
  localparam int LenW  = 7;
  localparam int CntW  = 16;
  localparam int KindW = 3;
  localparam int SlotW = 6;
  localparam int CfgAw = 3;
  localparam int CfgDw = 32;

  localparam logic [ByteW-1:0] AckHeader   = 8'h06;
  localparam logic [2:0]       AckLastByte = 3'd4;
  localparam logic [CntW-1:0]  RetryRst    = 16'd3000;
  localparam logic [CntW-1:0]  DropRst     = 16'd5000;

  typedef enum logic [0:0] {
    REG_RETRY_TICKS,
    REG_DROP_TICKS
  } reg_idx_t;

  typedef enum logic [OpW-1:0] {
    OP_SEND,
    OP_ACK,
    OP_TICK,
    OP_NONE
  } op_t;

  typedef enum logic [KindW-1:0] {
    EV_SENT,
    EV_RETRANSMIT,
    EV_DROPPED,
    EV_ACKED,
    EV_UNKNOWN,
    EV_ILLEGAL
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_MATCH,
    ST_TICK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [LenW-1:0] len;
    logic [CntW-1:0] cnt;
    logic            retried;
  } slot_entry_t;

  typedef struct packed {
    logic        emit;
    kind_t       kind;
    logic        wr_en;
    logic        clr_busy;
    slot_entry_t wdata;
  } unit_res_t;

endpackage

// ===== design/acktt_if.sv =====
// word channels of the ack retransmit tracking table: input channel and result channel
// depends on acktt_pkg for field widths

interface acktt_in_if;
  logic                          valid;
  logic                          ready;
  logic [acktt_pkg::OpW-1:0]     operation;
  logic [acktt_pkg::ByteW-1:0]   ack_byte;
  logic [acktt_pkg::LenW-1:0]    payload_length;

  modport source (output valid, output operation, output ack_byte, output payload_length,
                  input ready);
  modport sink   (input valid, input operation, input ack_byte, input payload_length,
                  output ready);
endinterface

interface acktt_out_if;
  logic                          valid;
  logic                          ready;
  logic [acktt_pkg::KindW-1:0]   event_kind;
  logic [acktt_pkg::SlotW-1:0]   slot_index;
  logic [acktt_pkg::IdW-1:0]     message_id;
  logic [acktt_pkg::LenW-1:0]    message_length;
  logic                          is_table_full;
  logic                          last;

  modport source (output valid, output event_kind, output slot_index, output message_id,
                  output message_length, output is_table_full, output last, input ready);
  modport sink   (input valid, input event_kind, input slot_index, input message_id,
                  input message_length, input is_table_full, input last, output ready);
endinterface

// ===== design/acktt_slot_mem.sv =====
// slot table memory: id, length, countdown and retry flag of each slot
// one write port, one read port with registered read data; depends on acktt_pkg

module acktt_slot_mem #(
  parameter int SLOTS = acktt_pkg::SlotsDef
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  acktt_pkg::slot_entry_t wdata,
  input  logic                   re,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  output acktt_pkg::slot_entry_t rdata
);

  acktt_pkg::slot_entry_t mem_r [SLOTS];
  acktt_pkg::slot_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/acktt_slot_unit.sv =====
// shared slot unit: id compare for ack matching, countdown decrement and expiry for ticks
// used once per slot by the walk in the top level; depends on acktt_pkg

module acktt_slot_unit (
  input  logic                           valid,
  input  logic                           is_tick,
  input  logic                           busy,
  input  acktt_pkg::slot_entry_t         entry,
  input  logic [acktt_pkg::IdW-1:0]      match_id,
  input  logic [acktt_pkg::CntW-1:0]     drop_ticks,
  output acktt_pkg::unit_res_t           res
);

  always_comb begin
    res       = '0;
    res.kind  = acktt_pkg::EV_ACKED;
    res.wdata = entry;
    if (valid && busy) begin
      if (!is_tick) begin
        if (entry.id == match_id) begin
          res.emit     = 1'b1;
          res.clr_busy = 1'b1;
        end
      end else if (entry.cnt > acktt_pkg::CntW'(1)) begin
        res.wr_en     = 1'b1;
        res.wdata.cnt = entry.cnt - acktt_pkg::CntW'(1);
      end else if (!entry.retried) begin
        // first expiry: resend once and wait the drop time
        res.wr_en         = 1'b1;
        res.wdata.retried = 1'b1;
        res.wdata.cnt     = drop_ticks;
        res.emit          = 1'b1;
        res.kind          = acktt_pkg::EV_RETRANSMIT;
      end else begin
        res.clr_busy = 1'b1;
        res.emit     = 1'b1;
        res.kind     = acktt_pkg::EV_DROPPED;
      end
    end
  end

endmodule

// ===== design/ack_retransmit_tracking_table.sv =====
// ack retransmit tracking table, top level: sequencer, slot flags, ack gathering, config
// depends on acktt_pkg, acktt_if, acktt_slot_mem and acktt_slot_unit
//
// The table holds SLOTS outstanding messages. A send scans the busy flags one slot per cycle
// and takes the lowest free one. The first four bytes of an ack are gathered while the block
// stays idle; the fifth starts, if the header byte was good, a walk of the slot memory, one
// slot per cycle through its single read port, that ends at the first match or after the
// last slot. A tick walks every slot through the same memory port and the shared countdown
// unit, and the result side can stall it. The input is ready only while the block is idle.
// Results leave through an output register, and the last result of an item carries last;
// the next item may be taken while it still waits.
// Configuration sits on an APB-style port: retry_ticks at 0x0, drop_ticks at 0x4.

module ack_retransmit_tracking_table #(
  parameter int SLOTS = acktt_pkg::SlotsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  acktt_in_if.sink                      in_ch,
  acktt_out_if.source                   out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acktt_pkg::CfgAw-1:0]   paddr,
  input  logic [acktt_pkg::CfgDw-1:0]   pwdata,
  output logic [acktt_pkg::CfgDw-1:0]   prdata,
  output logic                          pready
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] LastIdx = CW'(SLOTS - 1);
  localparam logic [CW-1:0] EndIdx  = CW'(SLOTS);

  acktt_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]              rd_idx_r, rd_idx_nxt;
  logic                       ev_vld_r, ev_vld_nxt;
  logic [IW-1:0]              ev_idx_r, ev_idx_nxt;
  logic [SLOTS-1:0]           busy_r, busy_nxt;

  logic [acktt_pkg::IdW-1:0]  next_id_r, next_id_nxt;
  logic [2:0]                 ack_cnt_r, ack_cnt_nxt;
  logic                       hdr_good_r, hdr_good_nxt;
  logic [acktt_pkg::IdW-1:0]  gather_r, gather_nxt;
  logic [acktt_pkg::LenW-1:0] plen_r, plen_nxt;
  logic [acktt_pkg::CntW-1:0] retry_r, retry_nxt;
  logic [acktt_pkg::CntW-1:0] drop_r, drop_nxt;

  // one pending result held back so that last can be set once the walk is over
  logic                        pend_vld_r, pend_vld_nxt;
  logic [acktt_pkg::KindW-1:0] pend_kind_r, pend_kind_nxt;
  logic [acktt_pkg::SlotW-1:0] pend_slot_r, pend_slot_nxt;
  logic [acktt_pkg::IdW-1:0]   pend_id_r, pend_id_nxt;
  logic [acktt_pkg::LenW-1:0]  pend_len_r, pend_len_nxt;
  logic                        pend_full_r, pend_full_nxt;

  logic                        out_vld_r, out_vld_nxt;
  logic [acktt_pkg::KindW-1:0] out_kind_r, out_kind_nxt;
  logic [acktt_pkg::SlotW-1:0] out_slot_r, out_slot_nxt;
  logic [acktt_pkg::IdW-1:0]   out_id_r, out_id_nxt;
  logic [acktt_pkg::LenW-1:0]  out_len_r, out_len_nxt;
  logic                        out_full_r, out_full_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        mem_we;
  logic [IW-1:0]               mem_waddr;
  acktt_pkg::slot_entry_t      mem_wdata;
  logic                        mem_re;
  logic [IW-1:0]               mem_raddr;
  acktt_pkg::slot_entry_t      mem_rdata;
  acktt_pkg::unit_res_t        u_res;

  logic                        in_acc;
  acktt_pkg::op_t              op;
  logic                        out_free;
  logic                        stall;
  logic                        adv;
  logic                        scan_free;
  logic                        walk_end;
  logic                        cfg_wr;
  acktt_pkg::reg_idx_t         cfg_idx;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign op        = acktt_pkg::op_t'(in_ch.operation);
  assign out_free  = !out_vld_r || out_ch.ready;
  assign stall     = ev_vld_r && u_res.emit && pend_vld_r && !out_free;
  assign adv       = !stall;
  assign scan_free = !busy_r[rd_idx_r[IW-1:0]];
  assign walk_end  = (rd_idx_r == EndIdx);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cfg_idx   = acktt_pkg::reg_idx_t'(paddr[2]);

  acktt_slot_mem #(
    .SLOTS (SLOTS)
  ) u_slot_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  acktt_slot_unit u_slot_unit (
    .valid      (ev_vld_r),
    .is_tick    (state_r == acktt_pkg::ST_TICK),
    .busy       (busy_r[ev_idx_r]),
    .entry      (mem_rdata),
    .match_id   (gather_r),
    .drop_ticks (drop_r),
    .res        (u_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      acktt_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (op)
            acktt_pkg::OP_SEND: state_nxt = acktt_pkg::ST_SEND;
            acktt_pkg::OP_ACK: begin
              if (ack_cnt_r == acktt_pkg::AckLastByte) begin
                state_nxt = hdr_good_r ? acktt_pkg::ST_MATCH : acktt_pkg::ST_FLUSH;
              end
            end
            acktt_pkg::OP_TICK: state_nxt = acktt_pkg::ST_TICK;
            default:            state_nxt = acktt_pkg::ST_IDLE;
          endcase
        end
      end
      acktt_pkg::ST_SEND: begin
        if (scan_free || rd_idx_r == LastIdx) begin
          state_nxt = acktt_pkg::ST_FLUSH;
        end
      end
      acktt_pkg::ST_MATCH: begin
        if (u_res.emit || walk_end) begin
          state_nxt = acktt_pkg::ST_FLUSH;
        end
      end
      acktt_pkg::ST_TICK: begin
        if (walk_end && adv) begin
          state_nxt = acktt_pkg::ST_FLUSH;
        end
      end
      acktt_pkg::ST_FLUSH: begin
        if (!pend_vld_r || out_free) begin
          state_nxt = acktt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = acktt_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rd_idx_nxt    = rd_idx_r;
    ev_vld_nxt    = ev_vld_r;
    ev_idx_nxt    = ev_idx_r;
    busy_nxt      = busy_r;
    next_id_nxt   = next_id_r;
    ack_cnt_nxt   = ack_cnt_r;
    hdr_good_nxt  = hdr_good_r;
    gather_nxt    = gather_r;
    plen_nxt      = plen_r;
    retry_nxt     = retry_r;
    drop_nxt      = drop_r;
    pend_vld_nxt  = pend_vld_r;
    pend_kind_nxt = pend_kind_r;
    pend_slot_nxt = pend_slot_r;
    pend_id_nxt   = pend_id_r;
    pend_len_nxt  = pend_len_r;
    pend_full_nxt = pend_full_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_id_nxt    = out_id_r;
    out_len_nxt   = out_len_r;
    out_full_nxt  = out_full_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = ev_idx_r;
    mem_wdata     = u_res.wdata;
    mem_re        = 1'b0;
    mem_raddr     = rd_idx_r[IW-1:0];

    if (cfg_wr) begin
      case (cfg_idx)
        acktt_pkg::REG_RETRY_TICKS: retry_nxt = pwdata[acktt_pkg::CntW-1:0];
        acktt_pkg::REG_DROP_TICKS:  drop_nxt  = pwdata[acktt_pkg::CntW-1:0];
        default: ;
      endcase
    end

    case (state_r)
      acktt_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (op)
            acktt_pkg::OP_SEND: begin
              rd_idx_nxt = '0;
              plen_nxt   = in_ch.payload_length;
            end
            acktt_pkg::OP_ACK: begin
              case (ack_cnt_r)
                3'd0: begin
                  hdr_good_nxt = (in_ch.ack_byte == acktt_pkg::AckHeader);
                  gather_nxt   = '0;
                end
                3'd1:    gather_nxt[7:0]   = in_ch.ack_byte;
                3'd2:    gather_nxt[15:8]  = in_ch.ack_byte;
                3'd3:    gather_nxt[23:16] = in_ch.ack_byte;
                default: gather_nxt[31:24] = in_ch.ack_byte;
              endcase
              if (ack_cnt_r == acktt_pkg::AckLastByte) begin
                ack_cnt_nxt = '0;
                rd_idx_nxt  = '0;
                ev_vld_nxt  = 1'b0;
                if (!hdr_good_r) begin
                  pend_vld_nxt  = 1'b1;
                  pend_kind_nxt = acktt_pkg::EV_ILLEGAL;
                  pend_slot_nxt = '0;
                  pend_id_nxt   = '0;
                  pend_len_nxt  = '0;
                  pend_full_nxt = 1'b0;
                end
              end else begin
                ack_cnt_nxt = ack_cnt_r + 3'd1;
              end
            end
            acktt_pkg::OP_TICK: begin
              rd_idx_nxt = '0;
              ev_vld_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end

      acktt_pkg::ST_SEND: begin
        if (scan_free) begin
          mem_we             = 1'b1;
          mem_waddr          = rd_idx_r[IW-1:0];
          mem_wdata.id       = next_id_r;
          mem_wdata.len      = plen_r;
          mem_wdata.cnt      = retry_r;
          mem_wdata.retried  = 1'b0;
          busy_nxt[rd_idx_r[IW-1:0]] = 1'b1;
          next_id_nxt        = next_id_r + acktt_pkg::IdW'(1);
          pend_vld_nxt       = 1'b1;
          pend_kind_nxt      = acktt_pkg::EV_SENT;
          pend_slot_nxt      = acktt_pkg::SlotW'(rd_idx_r);
          pend_id_nxt        = next_id_r;
          pend_len_nxt       = plen_r;
          pend_full_nxt      = 1'b0;
        end else if (rd_idx_r == LastIdx) begin
          pend_vld_nxt  = 1'b1;
          pend_kind_nxt = acktt_pkg::EV_ILLEGAL;
          pend_slot_nxt = '0;
          pend_id_nxt   = '0;
          pend_len_nxt  = '0;
          pend_full_nxt = 1'b1;
        end else begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
      end

      acktt_pkg::ST_MATCH: begin
        if (u_res.emit) begin
          busy_nxt[ev_idx_r] = 1'b0;
          pend_vld_nxt  = 1'b1;
          pend_kind_nxt = acktt_pkg::EV_ACKED;
          pend_slot_nxt = acktt_pkg::SlotW'(ev_idx_r);
          pend_id_nxt   = mem_rdata.id;
          pend_len_nxt  = mem_rdata.len;
          pend_full_nxt = 1'b0;
        end else if (walk_end) begin
          pend_vld_nxt  = 1'b1;
          pend_kind_nxt = acktt_pkg::EV_UNKNOWN;
          pend_slot_nxt = '0;
          pend_id_nxt   = gather_r;
          pend_len_nxt  = '0;
          pend_full_nxt = 1'b0;
        end else begin
          mem_re     = 1'b1;
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = rd_idx_r[IW-1:0];
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
      end

      acktt_pkg::ST_TICK: begin
        if (adv) begin
          mem_we = u_res.wr_en;
          if (u_res.clr_busy) begin
            busy_nxt[ev_idx_r] = 1'b0;
          end
          if (u_res.emit) begin
            // earlier result goes out first, not the last of this tick
            if (pend_vld_r) begin
              out_vld_nxt  = 1'b1;
              out_kind_nxt = pend_kind_r;
              out_slot_nxt = pend_slot_r;
              out_id_nxt   = pend_id_r;
              out_len_nxt  = pend_len_r;
              out_full_nxt = pend_full_r;
              out_last_nxt = 1'b0;
            end
            pend_vld_nxt  = 1'b1;
            pend_kind_nxt = u_res.kind;
            pend_slot_nxt = acktt_pkg::SlotW'(ev_idx_r);
            pend_id_nxt   = mem_rdata.id;
            pend_len_nxt  = mem_rdata.len;
            pend_full_nxt = 1'b0;
          end
          if (walk_end) begin
            ev_vld_nxt = 1'b0;
          end else begin
            mem_re     = 1'b1;
            ev_vld_nxt = 1'b1;
            ev_idx_nxt = rd_idx_r[IW-1:0];
            rd_idx_nxt = rd_idx_r + CW'(1);
          end
        end
      end

      acktt_pkg::ST_FLUSH: begin
        ev_vld_nxt = 1'b0;
        if (pend_vld_r && out_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = pend_kind_r;
          out_slot_nxt = pend_slot_r;
          out_id_nxt   = pend_id_r;
          out_len_nxt  = pend_len_r;
          out_full_nxt = pend_full_r;
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= acktt_pkg::ST_IDLE;
      rd_idx_r   <= '0;
      ev_vld_r   <= 1'b0;
      busy_r     <= '0;
      next_id_r  <= '0;
      ack_cnt_r  <= '0;
      hdr_good_r <= 1'b0;
      gather_r   <= '0;
      retry_r    <= acktt_pkg::RetryRst;
      drop_r     <= acktt_pkg::DropRst;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_idx_r   <= rd_idx_nxt;
      ev_vld_r   <= ev_vld_nxt;
      busy_r     <= busy_nxt;
      next_id_r  <= next_id_nxt;
      ack_cnt_r  <= ack_cnt_nxt;
      hdr_good_r <= hdr_good_nxt;
      gather_r   <= gather_nxt;
      retry_r    <= retry_nxt;
      drop_r     <= drop_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r    <= ev_idx_nxt;
    plen_r      <= plen_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_len_r  <= pend_len_nxt;
    pend_full_r <= pend_full_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_id_r    <= out_id_nxt;
    out_len_r   <= out_len_nxt;
    out_full_r  <= out_full_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    case (cfg_idx)
      acktt_pkg::REG_RETRY_TICKS: prdata = acktt_pkg::CfgDw'(retry_r);
      acktt_pkg::REG_DROP_TICKS:  prdata = acktt_pkg::CfgDw'(drop_r);
      default:                    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  assign in_ch.ready           = (state_r == acktt_pkg::ST_IDLE);
  assign out_ch.valid          = out_vld_r;
  assign out_ch.event_kind     = out_kind_r;
  assign out_ch.slot_index     = out_slot_r;
  assign out_ch.message_id     = out_id_r;
  assign out_ch.message_length = out_len_r;
  assign out_ch.is_table_full  = out_full_r;
  assign out_ch.last           = out_last_r;

endmodule

// ===== design/acktt_checker.sv =====
// port-level checks of the ack retransmit tracking table, bound to the top level
// depends on acktt_pkg and ack_retransmit_tracking_table

module acktt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [acktt_pkg::OpW-1:0]     in_operation,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [acktt_pkg::KindW-1:0]   out_event_kind,
  input logic [acktt_pkg::SlotW-1:0]   out_slot_index,
  input logic [acktt_pkg::IdW-1:0]     out_message_id,
  input logic                          out_is_table_full,
  input logic                          out_last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind)
      && $stable(out_slot_index) && $stable(out_message_id))
    else $error("result word changed while stalled");

  // a refused send is a single illegal-kind word
  a_full_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_table_full |-> out_event_kind == acktt_pkg::EV_ILLEGAL && out_last)
    else $error("table full flag on wrong kind or not last");

  a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == acktt_pkg::EV_UNKNOWN
      || out_event_kind == acktt_pkg::EV_ILLEGAL) |-> out_slot_index == '0)
    else $error("slot index set on unknown or illegal ack");

  // a send always runs the slot scan
  a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == acktt_pkg::OP_SEND |=> !in_ready)
    else $error("ready right after a send");

  a_nop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == acktt_pkg::OP_NONE |=> in_ready)
    else $error("unused operation made the block busy");

endmodule

bind ack_retransmit_tracking_table acktt_checker u_acktt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_operation      (in_ch.operation),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_event_kind    (out_ch.event_kind),
  .out_slot_index    (out_ch.slot_index),
  .out_message_id    (out_ch.message_id),
  .out_is_table_full (out_ch.is_table_full),
  .out_last          (out_ch.last)
);
